// ===== rtl/display_fill_rect_byte_stream_assert.svh =====
// Assertion macros for the fill-rectangle byte stream block.
// Used by the checker; expects clk and rst in scope.
`ifndef DISPLAY_FILL_RECT_BYTE_STREAM_ASSERT_SVH
`define DISPLAY_FILL_RECT_BYTE_STREAM_ASSERT_SVH

// same-cycle implication
`define DFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fill-rect stream check failed");

// next-cycle implication
`define DFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fill-rect stream check failed");

`endif

// ===== rtl/dfr_pkg.sv =====
// Shared types and constants for the fill-rectangle byte stream block.
// No dependencies.
`default_nettype none

package dfr_pkg;

  localparam int unsigned DIM_W       = 9;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned IN_TDATA_W  = 56;  // 4*9 + 16 = 52, padded to bytes
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned PBC_W       = 10;
  localparam int unsigned BIDX_W      = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  localparam logic [7:0] DCS_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] DCS_ROW_SET      = 8'h2B;
  localparam logic [7:0] DCS_MEMORY_WRITE = 8'h2C;

  typedef enum logic [2:0] {
    PH_COL = 3'b001,
    PH_ROW = 3'b010,
    PH_MEM = 3'b100
  } phase_t;

  typedef struct packed {
    logic               cmd;
    logic [DIM_W-1:0]   x;
    logic [DIM_W-1:0]   y;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COLOR_W-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       end_of_command;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/display_fill_rect_byte_stream.sv =====
// Fill-rectangle byte stream generator, top level.
// Depends on dfr_pkg, dfr_in_reg, dfr_engine, dfr_out_reg.
//
// A load request (tuser 0) stores a rectangle and colour; each pull request
// (tuser 1) yields the next byte of the display command stream: per row a
// column set (0x2A, start, end), a row set (0x2B, row, row) and a memory
// write (0x2C, then width colour pairs, high byte first). Requests are taken
// one per clock while the output is not stalled; a byte passes from the input
// register through the one-step sequencer to the result register before it is
// presented. A pull while idle and a load of zero width or height give no
// output. Loading a non-empty rectangle while one is in progress restarts the
// stream with the new one.
`default_nettype none

module display_fill_rect_byte_stream #(
  parameter int unsigned MAX_DIM = 320
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [8:0] x, [17:9] y, [26:18] width, [35:27] height, [51:36] color, rest 0
  input  wire logic [dfr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] cmd
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] out_byte
  output logic [dfr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // [0] is_data, [1] end_of_command
  output logic [dfr_pkg::OUT_TUSER_W-1:0]        m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import dfr_pkg::*;

  logic      in_valid;
  in_item_t  in_item;
  logic      free;
  logic      step;
  logic      res_valid;
  out_item_t res;

  assign step = in_valid && free;

  dfr_in_reg u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take          (free),
    .valid         (in_valid),
    .item          (in_item)
  );

  dfr_engine #(
    .MAX_DIM (MAX_DIM)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  dfr_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (res_valid),
    .res           (res),
    .free          (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/dfr_in_reg.sv =====
// Input register: captures one request transfer and unpacks its fields.
// Depends on dfr_pkg.
`default_nettype none

module dfr_in_reg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [dfr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tuser,
  input  wire logic                             take,
  output logic                                  valid,
  output dfr_pkg::in_item_t                     item
);
  import dfr_pkg::*;

  logic     valid_next;
  in_item_t item_next;

  assign s_axis_tready = !valid || take;

  always_comb begin
    item_next.cmd    = s_axis_tuser;
    item_next.x      = s_axis_tdata[8:0];
    item_next.y      = s_axis_tdata[17:9];
    item_next.width  = s_axis_tdata[26:18];
    item_next.height = s_axis_tdata[35:27];
    item_next.color  = s_axis_tdata[51:36];
    valid_next       = s_axis_tready ? s_axis_tvalid : valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfr_engine.sv =====
// Stream sequencer: rectangle state plus the per-item next-byte logic.
// Depends on dfr_pkg.
`default_nettype none

module dfr_engine #(
  parameter int unsigned MAX_DIM = 320
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire dfr_pkg::in_item_t item,
  output logic             res_valid,
  output dfr_pkg::out_item_t res
);
  import dfr_pkg::*;

  // 9-bit inputs cannot exceed 511, so a larger cap never bites
  localparam int unsigned    DimCapInt = (MAX_DIM > 511) ? 511 : MAX_DIM;
  localparam logic [DIM_W-1:0] DimCap = DIM_W'(DimCapInt);

  logic                busy, busy_next;
  phase_t              phase, phase_next;
  logic [BIDX_W-1:0]   byte_index, byte_index_next;
  logic [PBC_W-1:0]    pixel_byte_count, pixel_byte_count_next;
  logic [DIM_W-1:0]    row_count, row_count_next;
  logic [DIM_W-1:0]    saved_x, saved_y, saved_width, saved_height;
  logic [COLOR_W-1:0]  saved_color;

  logic                load_ok;
  logic [DIM_W-1:0]    w_cap, h_cap;
  logic [9:0]          col_end, row_addr;
  logic [15:0]         first, second, addr_val;
  logic [BIDX_W-1:0]   k;
  logic [PBC_W-1:0]    pbc_inc;
  logic [9:0]          row_inc;

  always_comb begin
    w_cap    = (item.width > DimCap) ? DimCap : item.width;
    h_cap    = (item.height > DimCap) ? DimCap : item.height;
    load_ok  = (item.width != '0) && (item.height != '0);
    col_end  = {1'b0, saved_x} + {1'b0, saved_width} - 10'd1;
    row_addr = {1'b0, saved_y} + {1'b0, row_count};
    first    = (phase == PH_COL) ? {7'd0, saved_x} : {6'd0, row_addr};
    second   = (phase == PH_COL) ? {6'd0, col_end} : {6'd0, row_addr};
    k        = (byte_index > BIDX_W'(4)) ? BIDX_W'(4) : byte_index;
    addr_val = (k <= BIDX_W'(2)) ? first : second;
    pbc_inc  = pixel_byte_count + PBC_W'(1);
    row_inc  = {1'b0, row_count} + 10'd1;

    busy_next             = busy;
    phase_next            = phase;
    byte_index_next       = byte_index;
    pixel_byte_count_next = pixel_byte_count;
    row_count_next        = row_count;
    res_valid             = 1'b0;
    res                   = '0;

    if (step && item.cmd == CMD_LOAD) begin
      if (load_ok) begin
        busy_next             = 1'b1;
        phase_next            = PH_COL;
        byte_index_next       = '0;
        pixel_byte_count_next = '0;
        row_count_next        = '0;
      end
    end else if (step && busy) begin
      res_valid = 1'b1;
      case (phase)
        PH_COL, PH_ROW: begin
          if (byte_index == '0) begin
            res.out_byte    = (phase == PH_COL) ? DCS_COLUMN_SET : DCS_ROW_SET;
            byte_index_next = BIDX_W'(1);
          end else begin
            res.is_data  = 1'b1;
            res.out_byte = k[0] ? addr_val[15:8] : addr_val[7:0];
            if (k == BIDX_W'(4)) begin
              res.end_of_command = 1'b1;
              byte_index_next    = '0;
              phase_next         = (phase == PH_COL) ? PH_ROW : PH_MEM;
            end else begin
              byte_index_next = k + BIDX_W'(1);
            end
          end
        end
        default: begin
          if (byte_index == '0) begin
            res.out_byte          = DCS_MEMORY_WRITE;
            byte_index_next       = BIDX_W'(1);
            pixel_byte_count_next = '0;
          end else begin
            res.is_data           = 1'b1;
            res.out_byte          = pixel_byte_count[0] ? saved_color[7:0]
                                                        : saved_color[15:8];
            pixel_byte_count_next = pbc_inc;
            if (pbc_inc >= {saved_width, 1'b0}) begin
              res.end_of_command    = 1'b1;
              pixel_byte_count_next = '0;
              byte_index_next       = '0;
              phase_next            = PH_COL;
              if (row_inc >= {1'b0, saved_height}) begin
                res.last       = 1'b1;
                busy_next      = 1'b0;
                row_count_next = '0;
              end else begin
                row_count_next = row_inc[DIM_W-1:0];
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      phase            <= PH_COL;
      byte_index       <= '0;
      pixel_byte_count <= '0;
      row_count        <= '0;
    end else begin
      busy             <= busy_next;
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      pixel_byte_count <= pixel_byte_count_next;
      row_count        <= row_count_next;
    end
  end

  // rectangle payload, written only by an accepted non-empty load
  always_ff @(posedge clk) begin
    if (step && item.cmd == CMD_LOAD && load_ok) begin
      saved_x      <= item.x;
      saved_y      <= item.y;
      saved_width  <= w_cap;
      saved_height <= h_cap;
      saved_color  <= item.color;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfr_out_reg.sv =====
// Result register: holds one byte transfer until the sink takes it.
// Depends on dfr_pkg.
`default_nettype none

module dfr_out_reg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire dfr_pkg::out_item_t                res,
  output logic                                   free,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [dfr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic [dfr_pkg::OUT_TUSER_W-1:0]        m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import dfr_pkg::*;

  logic      valid, valid_next;
  out_item_t held;

  assign free          = !valid || m_axis_tready;
  assign valid_next    = load || (valid && !m_axis_tready);
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = held.out_byte;
  assign m_axis_tuser  = {held.end_of_command, held.is_data};
  assign m_axis_tlast  = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfr_checker.sv =====
// Port-level checks on the byte stream output, bound to the top level.
// Depends on dfr_pkg and display_fill_rect_byte_stream_assert.svh.
`default_nettype none

`include "display_fill_rect_byte_stream_assert.svh"

module dfr_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [dfr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire logic [dfr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  input wire logic                              m_axis_tlast
);
  import dfr_pkg::*;

  logic [OUT_TDATA_W+OUT_TUSER_W:0] out_bus;
  logic                             known_code;

  assign out_bus    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign known_code = m_axis_tdata inside {DCS_COLUMN_SET, DCS_ROW_SET, DCS_MEMORY_WRITE};

  // a stalled byte holds
  `DFR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_bus))

  // final byte of a rectangle also closes its memory write
  `DFR_ASSERT_NOW(a_last_eoc, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1] && m_axis_tuser[0])

  // a command byte opens a transaction, never closes one
  `DFR_ASSERT_NOW(a_cmd_open, m_axis_tvalid && !m_axis_tuser[0], !m_axis_tuser[1] && !m_axis_tlast)

  // command bytes are one of the three opcodes
  `DFR_ASSERT_NOW(a_cmd_code, m_axis_tvalid && !m_axis_tuser[0], known_code)

endmodule

bind display_fill_rect_byte_stream dfr_checker u_dfr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
